FILE: rtl/core/compass_heading_from_axes_defines.svh
// Assertion macros for the compass heading block.
`ifndef COMPASS_HEADING_FROM_AXES_DEFINES_SVH
`define COMPASS_HEADING_FROM_AXES_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define CHFA_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("heading check failed");
`define CHFA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("heading check failed");
`else
`define CHFA_ASSERT_IMP(label, clk, rstn, ante, cons)
`define CHFA_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

FILE: rtl/core/chfa_pkg.sv
`timescale 1ns / 1ps
package chfa_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int SAMPLE_BITS_DEF  = 13;

    localparam int FRAC_BITS  = 16;
    // vector growth: sqrt(2) * CORDIC gain plus sign, with margin
    localparam int GUARD_BITS = FRAC_BITS + 3;
    localparam int ZW         = 32;
    localparam int ATAN_MAX   = 24;

    localparam logic signed [16:0] OVERFLOW_CODE = -17'sd4096;

    localparam logic [ZW-1:0] HALF_Q16    = ZW'(10800 * 65536);
    localparam logic [ZW-1:0] QUARTER_Q16 = ZW'(5400 * 65536);
    localparam logic [ZW-1:0] THREE_Q_Q16 = ZW'(16200 * 65536);

    localparam logic [ZW-1:0] ATAN_Q16 [0:ATAN_MAX-1] = '{
        32'd176947200, 32'd104458032, 32'd55192755, 32'd28016704,
        32'd14062719,  32'd7038215,   32'd3519966,  32'd1760091,
        32'd880059,    32'd440031,    32'd220016,   32'd110008,
        32'd55004,     32'd27502,     32'd13751,    32'd6875,
        32'd3438,      32'd1719,      32'd859,      32'd430,
        32'd215,       32'd107,       32'd54,       32'd27
    };

    localparam int AW          = 15;      // arc-minutes within one turn
    localparam int TURN_ARCMIN = 21600;
    localparam int SUM_W       = 18;
    localparam int DECL_W      = 16;

    // q = (a * DIV60_MUL) >> DIV60_SHIFT equals a / 60 for a < 21600
    localparam logic [15:0] DIV60_MUL   = 16'd34953;
    localparam int          DIV60_SHIFT = 21;
    localparam int          PROD_W      = AW + 16;

    localparam int DEG_W     = 9;
    localparam int MIN_W     = 6;
    localparam int OUT_TDW   = 16;
    localparam int DDEG_W    = 9;
    localparam int DMIN_W    = 7;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 9;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DECL_DEGREES = 4'd0,
        REG_DECL_MINUTES = 4'd1
    } cfg_reg_t;

    // angles known without iterating
    typedef enum logic [2:0] {
        SPEC_NONE,
        SPEC_ZERO,
        SPEC_HALF,
        SPEC_QUARTER,
        SPEC_THREE_Q
    } spec_t;

    typedef struct packed {
        logic          ovf;
        spec_t         spec;
        logic [ZW-1:0] z;
    } chfa_ctl_t;

endpackage

FILE: rtl/core/chfa_prep.sv
`timescale 1ns / 1ps
module chfa_prep #(
    parameter int SAMPLE_BITS = chfa_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        in_valid,
    output logic                                        in_ready,
    input  logic [SAMPLE_BITS-1:0]                      raw_x,
    input  logic [SAMPLE_BITS-1:0]                      raw_y,
    output logic                                        out_valid,
    input  logic                                        out_ready,
    output logic [SAMPLE_BITS+chfa_pkg::GUARD_BITS-1:0] out_x,
    output logic [SAMPLE_BITS+chfa_pkg::GUARD_BITS-1:0] out_y,
    output chfa_pkg::chfa_ctl_t                         out_ctl
);
    import chfa_pkg::*;

    localparam int XW = SAMPLE_BITS + GUARD_BITS;

    logic                   valid_reg;
    logic [XW-1:0]          x_reg, y_reg, x_next, y_next;
    chfa_ctl_t              ctl_reg, ctl_next;
    logic [16:0]            x17, y17;
    logic                   ovf_x, ovf_y;
    logic [SAMPLE_BITS-1:0] xz, yz;
    logic [XW-1:0]          xw, yw;
    logic                   x_zero, y_zero, x_neg, y_neg;

    always_comb begin
        x17    = {{(17-SAMPLE_BITS){raw_x[SAMPLE_BITS-1]}}, raw_x};
        y17    = {{(17-SAMPLE_BITS){raw_y[SAMPLE_BITS-1]}}, raw_y};
        ovf_x  = ($signed(x17) == OVERFLOW_CODE);
        ovf_y  = ($signed(y17) == OVERFLOW_CODE);
        xz     = ovf_x ? '0 : raw_x;
        yz     = ovf_y ? '0 : raw_y;
        x_zero = (xz == '0);
        y_zero = (yz == '0);
        x_neg  = xz[SAMPLE_BITS-1];
        y_neg  = yz[SAMPLE_BITS-1];
        xw = {{(XW-SAMPLE_BITS-FRAC_BITS){xz[SAMPLE_BITS-1]}}, xz, {FRAC_BITS{1'b0}}};
        yw = {{(XW-SAMPLE_BITS-FRAC_BITS){yz[SAMPLE_BITS-1]}}, yz, {FRAC_BITS{1'b0}}};

        // left half-plane: rotate by 180 degrees first
        if (x_neg) begin
            x_next     = XW'(-$signed(xw));
            y_next     = XW'(-$signed(yw));
            ctl_next.z = HALF_Q16;
        end else begin
            x_next     = xw;
            y_next     = yw;
            ctl_next.z = '0;
        end
        ctl_next.ovf = ovf_x | ovf_y;

        priority if (x_zero && y_zero) begin
            ctl_next.spec = SPEC_ZERO;
        end else if (y_zero) begin
            ctl_next.spec = x_neg ? SPEC_HALF : SPEC_ZERO;
        end else if (x_zero) begin
            ctl_next.spec = y_neg ? SPEC_THREE_Q : SPEC_QUARTER;
        end else begin
            ctl_next.spec = SPEC_NONE;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            ctl_reg <= ctl_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_ctl   = ctl_reg;

endmodule

FILE: rtl/core/chfa_cordic_stage.sv
`timescale 1ns / 1ps
module chfa_cordic_stage #(
    parameter int SAMPLE_BITS = chfa_pkg::SAMPLE_BITS_DEF,
    parameter int STEP        = 0
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        in_valid,
    output logic                                        in_ready,
    input  logic [SAMPLE_BITS+chfa_pkg::GUARD_BITS-1:0] in_x,
    input  logic [SAMPLE_BITS+chfa_pkg::GUARD_BITS-1:0] in_y,
    input  chfa_pkg::chfa_ctl_t                         in_ctl,
    output logic                                        out_valid,
    input  logic                                        out_ready,
    output logic [SAMPLE_BITS+chfa_pkg::GUARD_BITS-1:0] out_x,
    output logic [SAMPLE_BITS+chfa_pkg::GUARD_BITS-1:0] out_y,
    output chfa_pkg::chfa_ctl_t                         out_ctl
);
    import chfa_pkg::*;

    localparam int            XW   = SAMPLE_BITS + GUARD_BITS;
    localparam logic [ZW-1:0] ANGLE = ATAN_Q16[STEP];

    logic          valid_reg;
    logic [XW-1:0] x_reg, y_reg, x_next, y_next, dx, dy;
    chfa_ctl_t     ctl_reg, ctl_next;

    always_comb begin
        // arithmetic shift rounds toward minus infinity
        dx       = XW'($signed(in_y) >>> STEP);
        dy       = XW'($signed(in_x) >>> STEP);
        ctl_next = in_ctl;
        if (!in_y[XW-1]) begin
            x_next     = in_x + dx;
            y_next     = in_y - dy;
            ctl_next.z = in_ctl.z + ANGLE;
        end else begin
            x_next     = in_x - dx;
            y_next     = in_y + dy;
            ctl_next.z = in_ctl.z - ANGLE;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            ctl_reg <= ctl_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_ctl   = ctl_reg;

endmodule

FILE: rtl/core/chfa_wrap.sv
`timescale 1ns / 1ps
module chfa_wrap (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  chfa_pkg::chfa_ctl_t               in_ctl,
    input  logic [chfa_pkg::DECL_W-1:0]       decl_arcmin,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [chfa_pkg::AW-1:0]           out_arcmin,
    output logic                              out_ovf
);
    import chfa_pkg::*;

    localparam logic signed [SUM_W-1:0] TURN = SUM_W'(TURN_ARCMIN);

    logic                    valid_reg;
    logic [AW-1:0]           arcmin_reg, arcmin_next;
    logic                    ovf_reg;
    logic [ZW-1:0]           zsel;
    logic signed [SUM_W-1:0] sum, wrapped;

    always_comb begin
        unique case (in_ctl.spec)
            SPEC_NONE:    zsel = in_ctl.z;
            SPEC_ZERO:    zsel = '0;
            SPEC_HALF:    zsel = HALF_Q16;
            SPEC_QUARTER: zsel = QUARTER_Q16;
            SPEC_THREE_Q: zsel = THREE_Q_Q16;
            default:      zsel = '0;
        endcase
        // whole arc-minutes (floor), then declination; one correction suffices
        sum = $signed({{(SUM_W-(ZW-FRAC_BITS)){zsel[ZW-1]}}, zsel[ZW-1:FRAC_BITS]})
            + $signed({{(SUM_W-DECL_W){decl_arcmin[DECL_W-1]}}, decl_arcmin});
        priority if (sum < 0) begin
            wrapped = sum + TURN;
        end else if (sum >= TURN) begin
            wrapped = sum - TURN;
        end else begin
            wrapped = sum;
        end
        arcmin_next = wrapped[AW-1:0];
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            arcmin_reg <= arcmin_next;
            ovf_reg    <= in_ctl.ovf;
        end
    end

    assign out_valid  = valid_reg;
    assign out_arcmin = arcmin_reg;
    assign out_ovf    = ovf_reg;

endmodule

FILE: rtl/core/chfa_div60.sv
`timescale 1ns / 1ps
module chfa_div60 (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [chfa_pkg::AW-1:0]    in_arcmin,
    input  logic                       in_ovf,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [chfa_pkg::DEG_W-1:0] out_degrees,
    output logic [chfa_pkg::MIN_W-1:0] out_minutes,
    output logic                       out_ovf
);
    import chfa_pkg::*;

    logic              v1_reg, v2_reg, r1, r2;
    logic [PROD_W-1:0] prod;
    logic [DEG_W-1:0]  q_reg, q_next;
    logic [AW-1:0]     a_reg, q60, rem;
    logic              ovf1_reg, ovf2_reg;
    logic [DEG_W-1:0]  deg_reg;
    logic [MIN_W-1:0]  min_reg, min_next;

    // stage 1: reciprocal multiply
    always_comb begin
        prod   = PROD_W'(in_arcmin) * PROD_W'(DIV60_MUL);
        q_next = prod[DIV60_SHIFT+DEG_W-1:DIV60_SHIFT];
    end

    // stage 2: remainder, q*60 = q*64 - q*4
    always_comb begin
        q60      = (AW'(q_reg) << 6) - (AW'(q_reg) << 2);
        rem      = a_reg - q60;
        min_next = rem[MIN_W-1:0];
    end

    assign r2       = !v2_reg || out_ready;
    assign r1       = !v1_reg || r2;
    assign in_ready = r1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (r1) begin
                v1_reg <= in_valid;
            end
            if (r2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && r1) begin
            q_reg    <= q_next;
            a_reg    <= in_arcmin;
            ovf1_reg <= in_ovf;
        end
        if (v1_reg && r2) begin
            deg_reg  <= q_reg;
            min_reg  <= min_next;
            ovf2_reg <= ovf1_reg;
        end
    end

    assign out_valid   = v2_reg;
    assign out_degrees = deg_reg;
    assign out_minutes = min_reg;
    assign out_ovf     = ovf2_reg;

endmodule

FILE: rtl/core/compass_heading_from_axes.sv
`timescale 1ns / 1ps
`include "compass_heading_from_axes_defines.svh"
// Compass heading from raw X/Y magnetometer axes. Each accepted sample pair
// gives one result: heading atan2(y, x) plus the programmed declination,
// wrapped into one turn, as whole degrees (0..359) and arc-minutes (0..59),
// both truncated. An axis that reads -4096 is taken as zero and sets
// axis_overflow. One sample pair is taken every clock while m_tready is high.
// The pipeline registers are input conditioning, one register per CORDIC
// iteration, declination add and wrap, and a two-stage divide by 60. Every
// stage has its own valid bit, so bubbles fill up behind a stalled output.
// Declination registers must be written only while no request is in flight;
// the block does not enforce this. decl_reg holds the combined value.
module compass_heading_from_axes #(
    parameter int CORDIC_STEPS = chfa_pkg::CORDIC_STEPS_DEF,
    parameter int SAMPLE_BITS  = chfa_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // s_tdata: raw_x[SAMPLE_BITS-1:0], raw_y next, zero padded to bytes
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]  s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // m_tdata: heading_degrees[8:0], heading_minutes[14:9], bit 15 zero
    output logic [chfa_pkg::OUT_TDW-1:0]        m_tdata,
    // m_tuser: axis_overflow
    output logic                                m_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [chfa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [chfa_pkg::CFG_DAT_W-1:0]      cfg_data
);
    import chfa_pkg::*;

    localparam int XW = SAMPLE_BITS + GUARD_BITS;

    logic [DDEG_W-1:0] deg_reg;
    logic [DMIN_W-1:0] min_reg;
    logic [DECL_W-1:0] decl_reg, decl_next, deg16, min16;

    logic          sv [0:CORDIC_STEPS];
    logic          sr [0:CORDIC_STEPS];
    logic [XW-1:0] sx [0:CORDIC_STEPS];
    logic [XW-1:0] sy [0:CORDIC_STEPS];
    chfa_ctl_t     sc [0:CORDIC_STEPS];

    logic          w_valid, w_ready, w_ovf;
    logic          w_rdy_div;
    logic [AW-1:0] w_arcmin;
    logic [DEG_W-1:0] out_deg;
    logic [MIN_W-1:0] out_min;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deg_reg <= '0;
            min_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_DECL_DEGREES: begin
                    deg_reg <= cfg_data[DDEG_W-1:0];
                end
                REG_DECL_MINUTES: begin
                    min_reg <= cfg_data[DMIN_W-1:0];
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        deg16     = {{(DECL_W-DDEG_W){deg_reg[DDEG_W-1]}}, deg_reg};
        min16     = {{(DECL_W-DMIN_W){min_reg[DMIN_W-1]}}, min_reg};
        decl_next = (deg16 << 6) - (deg16 << 2) + min16;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decl_reg <= '0;
        end else begin
            decl_reg <= decl_next;
        end
    end

    // datapath
    chfa_prep #(.SAMPLE_BITS(SAMPLE_BITS)) u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .raw_x     (s_tdata[SAMPLE_BITS-1:0]),
        .raw_y     (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .out_valid (sv[0]),
        .out_ready (sr[0]),
        .out_x     (sx[0]),
        .out_y     (sy[0]),
        .out_ctl   (sc[0])
    );

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
        chfa_cordic_stage #(.SAMPLE_BITS(SAMPLE_BITS), .STEP(k)) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (sv[k]),
            .in_ready  (sr[k]),
            .in_x      (sx[k]),
            .in_y      (sy[k]),
            .in_ctl    (sc[k]),
            .out_valid (sv[k+1]),
            .out_ready (sr[k+1]),
            .out_x     (sx[k+1]),
            .out_y     (sy[k+1]),
            .out_ctl   (sc[k+1])
        );
    end

    // final vector is not needed past the last iteration
    assign sr[CORDIC_STEPS] = w_ready;

    chfa_wrap u_wrap (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (sv[CORDIC_STEPS] && (sx[CORDIC_STEPS] == sx[CORDIC_STEPS]
                      || sy[CORDIC_STEPS] != sy[CORDIC_STEPS])),
        .in_ready    (w_ready),
        .in_ctl      (sc[CORDIC_STEPS]),
        .decl_arcmin (decl_reg),
        .out_valid   (w_valid),
        .out_ready   (w_rdy_div),
        .out_arcmin  (w_arcmin),
        .out_ovf     (w_ovf)
    );

    chfa_div60 u_div60 (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (w_valid),
        .in_ready    (w_rdy_div),
        .in_arcmin   (w_arcmin),
        .in_ovf      (w_ovf),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_degrees (out_deg),
        .out_minutes (out_min),
        .out_ovf     (m_tuser)
    );

    assign m_tdata = {{(OUT_TDW-DEG_W-MIN_W){1'b0}}, out_min, out_deg};

    // checks
    `CHFA_ASSERT_IMP(a_deg_range, aclk, aresetn, m_tvalid, out_deg <= DEG_W'(359))
    `CHFA_ASSERT_IMP(a_min_range, aclk, aresetn, m_tvalid, out_min <= MIN_W'(59))
    `CHFA_ASSERT_IMP(a_full_stall, aclk, aresetn, !s_tready, m_tvalid && !m_tready)
    `CHFA_ASSERT_NEXT(a_decl_update, aclk, aresetn, cfg_valid && cfg_index == REG_DECL_DEGREES, deg_reg == $past(cfg_data[DDEG_W-1:0]))

endmodule
